/* rtl/pressure_temp_compensation_defines.svh */
// Assertion macros for the pressure/temperature compensation pipeline (ptc_pipe)
`ifndef PRESSURE_TEMP_COMPENSATION_DEFINES_SVH
`define PRESSURE_TEMP_COMPENSATION_DEFINES_SVH

// same-cycle implication, disabled in reset
`define PTC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define PTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ptc_pkg.sv */
// Types and constants for the pressure/temperature compensation block
package ptc_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SENS_BASE      = 3'd0,
    CFG_OFF_BASE       = 3'd1,
    CFG_SENS_TEMP_COEF = 3'd2,
    CFG_OFF_TEMP_COEF  = 3'd3,
    CFG_REF_TEMP_WORD  = 3'd4,
    CFG_TEMP_COEF_WORD = 3'd5
  } ptc_cfg_idx_e;

  typedef struct packed {
    logic [CfgW-1:0] c1;
    logic [CfgW-1:0] c2;
    logic [CfgW-1:0] c3;
    logic [CfgW-1:0] c4;
    logic [CfgW-1:0] c5;
    logic [CfgW-1:0] c6;
  } ptc_cfg_t;

  localparam logic signed [18:0] TEMP_REF = 19'sd2000;
  localparam logic signed [18:0] TEMP_MIN = $signed({1'b1, 18'd0});
  localparam logic signed [18:0] TEMP_MAX = $signed({1'b0, {18{1'b1}}});

endpackage

/* rtl/ptc_pipe.sv */
// Ten-stage compensation datapath with valid bits and a global stall
`include "pressure_temp_compensation_defines.svh"

module ptc_pipe import ptc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ptc_cfg_t            cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [23:0]         raw_pressure_i,
  input  logic [23:0]         raw_temperature_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [18:0]  temp_centi_o,
  output logic signed [31:0]  press_centi_mbar_o,
  output logic                low_temp_mode_o
);

  localparam int unsigned NStage = 10;

  logic [NStage-1:0] v_q;
  logic              adv;

  // stage 1
  logic signed [24:0] dt_d, dt_q;
  logic [23:0]        d1_q [0:4];
  // stage 2
  logic signed [41:0] tprod_d, oprod_d, sprod_d;
  logic signed [41:0] tprod_q, oprod_q, sprod_q;
  logic signed [49:0] dtsq_d;
  logic [47:0]        dtsq_q;
  // stage 3
  logic signed [41:0] tbias, obias, sbias;
  logic [51:0]        ti11;
  logic signed [17:0] dev_q;
  logic signed [34:0] offt_q;
  logic signed [33:0] senst_q;
  logic [16:0]        ti_q;
  // stage 4
  logic signed [35:0] sq_d;
  logic [16:0]        ti_sel;
  logic signed [19:0] t20;
  logic signed [18:0] temp2_d;
  logic signed [35:0] off_d, off_q;
  logic signed [34:0] sens_d, sens_q;
  logic [33:0]        sq_q;
  logic signed [18:0] temp2_q [0:6];
  logic               low_q [0:6];
  // stage 5
  logic [38:0]        offi31;
  logic [39:0]        sensi63;
  logic [35:0]        offi;
  logic [34:0]        sensi;
  logic signed [37:0] off2_d;
  logic signed [36:0] sens2_d, sens2_q;
  logic signed [37:0] off2_q [0:3];
  // stage 6
  logic [41:0]        pl_d, pl_q;
  logic signed [43:0] ph_d, ph_q;
  // stage 7
  logic signed [61:0] prod_d, prod_q;
  // stage 8
  logic signed [61:0] qbias;
  logic signed [40:0] q_q;
  // stage 9
  logic signed [41:0] r_d, r_q;
  // stage 10
  logic signed [41:0] rbias;
  logic signed [31:0] press_d, press_q;

  assign adv        = ~v_q[NStage-1] | out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NStage-2:0], in_valid_i};
    end
  end

  assign dt_d = $signed({1'b0, raw_temperature_i}) - $signed({1'b0, cfg_i.c5, 8'h00});

  assign tprod_d = dt_q * $signed({1'b0, cfg_i.c6});
  assign oprod_d = dt_q * $signed({1'b0, cfg_i.c4});
  assign sprod_d = dt_q * $signed({1'b0, cfg_i.c3});
  assign dtsq_d  = dt_q * dt_q;

  assign tbias = tprod_q + $signed({19'd0, {23{tprod_q[41]}}});
  assign obias = oprod_q + $signed({36'd0, {6{oprod_q[41]}}});
  assign sbias = sprod_q + $signed({35'd0, {7{sprod_q[41]}}});
  assign ti11  = {1'b0, dtsq_q, 3'b000} + {3'b000, dtsq_q, 1'b0} + {4'b0000, dtsq_q};

  assign sq_d   = dev_q * dev_q;
  assign ti_sel = dev_q[17] ? ti_q : 17'd0;
  assign t20    = $signed({{2{dev_q[17]}}, dev_q}) + TEMP_REF - $signed({3'b000, ti_sel});
  assign off_d  = $signed({3'b000, cfg_i.c2, 17'd0}) + $signed({offt_q[34], offt_q});
  assign sens_d = $signed({3'b000, cfg_i.c1, 16'd0}) + $signed({senst_q[33], senst_q});

  always_comb begin
    if (t20 < TEMP_MIN) begin
      temp2_d = TEMP_MIN;
    end else if (t20 > TEMP_MAX) begin
      temp2_d = TEMP_MAX;
    end else begin
      temp2_d = t20[18:0];
    end
  end

  assign offi31  = {sq_q, 5'd0} - {5'd0, sq_q};
  assign sensi63 = {sq_q, 6'd0} - {6'd0, sq_q};
  assign offi    = low_q[0] ? offi31[38:3] : 36'd0;
  assign sensi   = low_q[0] ? sensi63[39:5] : 35'd0;
  assign off2_d  = $signed({{2{off_q[35]}}, off_q}) - $signed({2'b00, offi});
  assign sens2_d = $signed({{2{sens_q[34]}}, sens_q}) - $signed({2'b00, sensi});

  assign pl_d = d1_q[4] * sens2_q[17:0];
  assign ph_d = $signed({1'b0, d1_q[4]}) * $signed(sens2_q[36:18]);

  assign prod_d = $signed({ph_q, 18'd0}) + $signed({20'd0, pl_q});

  assign qbias = prod_q + $signed({41'd0, {21{prod_q[61]}}});

  assign r_d = $signed({q_q[40], q_q}) - $signed({{4{off2_q[3][37]}}, off2_q[3]});

  assign rbias   = r_q + $signed({27'd0, {15{r_q[41]}}});
  assign press_d = $signed({{5{rbias[41]}}, rbias[41:15]});

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dt_q     <= dt_d;
      d1_q[0]  <= raw_pressure_i;
      for (int i = 1; i < 5; i++) begin
        d1_q[i] <= d1_q[i-1];
      end
      tprod_q  <= tprod_d;
      oprod_q  <= oprod_d;
      sprod_q  <= sprod_d;
      dtsq_q   <= dtsq_d[47:0];
      dev_q    <= tbias[40:23];
      offt_q   <= obias[40:6];
      senst_q  <= sbias[40:7];
      ti_q     <= ti11[51:35];
      sq_q     <= sq_d[33:0];
      off_q    <= off_d;
      sens_q   <= sens_d;
      temp2_q[0] <= temp2_d;
      low_q[0]   <= dev_q[17];
      for (int i = 1; i < 7; i++) begin
        temp2_q[i] <= temp2_q[i-1];
        low_q[i]   <= low_q[i-1];
      end
      sens2_q   <= sens2_d;
      off2_q[0] <= off2_d;
      for (int i = 1; i < 4; i++) begin
        off2_q[i] <= off2_q[i-1];
      end
      pl_q    <= pl_d;
      ph_q    <= ph_d;
      prod_q  <= prod_d;
      q_q     <= qbias[61:21];
      r_q     <= r_d;
      press_q <= press_d;
    end
  end

  assign out_valid_o        = v_q[NStage-1];
  assign temp_centi_o       = temp2_q[6];
  assign press_centi_mbar_o = press_q;
  assign low_temp_mode_o    = low_q[6];

  `PTC_ASSERT_NEXT(a_accept_enters, in_valid_i && in_ready_o, v_q[0], "accepted item lost at entry")
  `PTC_ASSERT_NEXT(a_stall_freezes, out_valid_o && !out_ready_i, $stable(v_q) && $stable(off2_q[3]), "pipeline moved during stall")
  `PTC_ASSERT_IMPL(a_low_below_ref, out_valid_o && low_temp_mode_o, temp_centi_o < TEMP_REF, "low mode with temperature at or above reference")
  `PTC_ASSERT_IMPL(a_high_from_ref, out_valid_o && !low_temp_mode_o, temp_centi_o >= TEMP_REF, "normal mode with temperature below reference")

endmodule

/* rtl/pressure_temp_compensation.sv */
// Top level: calibration registers and the compensation pipeline
// Throughput: one item per cycle through the ten-stage multiply pipeline, unless the output stalls.
// A stalled output freezes the whole pipeline; no item is dropped or repeated.
// Reset clears the calibration words to zero and empties the pipeline.
module pressure_temp_compensation import ptc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [23:0]         raw_pressure_i,
  input  logic [23:0]         raw_temperature_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [18:0]  temp_centi_o,
  output logic signed [31:0]  press_centi_mbar_o,
  output logic                low_temp_mode_o
);

  ptc_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SENS_BASE:      cfg_q.c1 <= cfg_wdata_i;
        CFG_OFF_BASE:       cfg_q.c2 <= cfg_wdata_i;
        CFG_SENS_TEMP_COEF: cfg_q.c3 <= cfg_wdata_i;
        CFG_OFF_TEMP_COEF:  cfg_q.c4 <= cfg_wdata_i;
        CFG_REF_TEMP_WORD:  cfg_q.c5 <= cfg_wdata_i;
        CFG_TEMP_COEF_WORD: cfg_q.c6 <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  ptc_pipe u_pipe (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .raw_pressure_i     (raw_pressure_i),
    .raw_temperature_i  (raw_temperature_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .temp_centi_o       (temp_centi_o),
    .press_centi_mbar_o (press_centi_mbar_o),
    .low_temp_mode_o    (low_temp_mode_o)
  );

endmodule

/* bench/compensation_checker.sv */
// Watches the compensation block's ports, predicts each reading and compares it with the output
module compensation_checker import ptc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [23:0]         raw_pressure_i,
  input  logic [23:0]         raw_temperature_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic signed [18:0]  temp_centi_i,
  input  logic signed [31:0]  press_centi_mbar_i,
  input  logic                low_temp_mode_i,
  output int                  outstanding_o,
  output int                  fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     MaxReports = 10;
  localparam longint TempRef    = longint'(TEMP_REF);
  localparam longint TempLo     = longint'(TEMP_MIN);
  localparam longint TempHi     = longint'(TEMP_MAX);
  localparam longint PressLo    = -(longint'(1) <<< 31);
  localparam longint PressHi    = (longint'(1) <<< 31) - 1;

  typedef struct packed {
    logic signed [18:0] temp;
    logic signed [31:0] press;
    logic               low;
  } reading_t;

  ptc_cfg_t cal;
  reading_t pending_readings[$];

  function automatic longint shr_tz(input longint x, input int unsigned k);
    longint m;
    m = (x < 0) ? -x : x;
    m = m >>> k;
    return (x < 0) ? -m : m;
  endfunction

  function automatic longint word(input logic [CfgW-1:0] w);
    return longint'({48'd0, w});
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic reading_t compensate(input logic [23:0] d1_raw, input logic [23:0] d2_raw);
    longint d1, dt, temp, off, sens, ti, offi, sensi, dev, sq, temp2, press;
    reading_t r;
    d1   = longint'({40'd0, d1_raw});
    dt   = longint'({40'd0, d2_raw}) - word(cal.c5) * 256;
    temp = TempRef + shr_tz(dt * word(cal.c6), 23);
    off  = word(cal.c2) * 131072 + shr_tz(word(cal.c4) * dt, 6);
    sens = word(cal.c1) * 65536 + shr_tz(word(cal.c3) * dt, 7);
    ti    = 0;
    offi  = 0;
    sensi = 0;
    r.low = (temp < TempRef);
    if (r.low) begin
      dev   = temp - TempRef;
      sq    = dev * dev;
      ti    = shr_tz(11 * dt * dt, 35);
      offi  = shr_tz(31 * sq, 3);
      sensi = shr_tz(63 * sq, 5);
    end
    temp2 = clamp(temp - ti, TempLo, TempHi);
    press = shr_tz(shr_tz(d1 * (sens - sensi), 21) - (off - offi), 15);
    press = clamp(press, PressLo, PressHi);
    r.temp  = temp2[18:0];
    r.press = press[31:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reading_t want;
    if (!rst_ni) begin
      cal = '0;
      pending_readings.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SENS_BASE:      cal.c1 = cfg_wdata_i;
          CFG_OFF_BASE:       cal.c2 = cfg_wdata_i;
          CFG_SENS_TEMP_COEF: cal.c3 = cfg_wdata_i;
          CFG_OFF_TEMP_COEF:  cal.c4 = cfg_wdata_i;
          CFG_REF_TEMP_WORD:  cal.c5 = cfg_wdata_i;
          CFG_TEMP_COEF_WORD: cal.c6 = cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (pending_readings.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= MaxReports)
            $display("%t: reading with no item pending: temp %0d press %0d low %0b",
                     $realtime, temp_centi_i, press_centi_mbar_i, low_temp_mode_i);
        end else begin
          want = pending_readings.pop_front();
          if (temp_centi_i !== want.temp || press_centi_mbar_i !== want.press ||
              low_temp_mode_i !== want.low) begin
            fail_count_o++;
            if (fail_count_o <= MaxReports)
              $display("%t: mismatch: expected temp %0d press %0d low %0b, got %0d %0d %0b",
                       $realtime, $signed(want.temp), $signed(want.press), want.low,
                       temp_centi_i, press_centi_mbar_i, low_temp_mode_i);
          end
        end
      end
      if (in_valid_i && in_ready_i)
        pending_readings.push_back(compensate(raw_pressure_i, raw_temperature_i));
    end
    outstanding_o = pending_readings.size();
  end

endmodule

/* bench/testbench.sv */
// Stimulus, clock, reset and verdict for the pressure/temperature compensation block
module testbench import ptc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ItemsPerPhase = 75;
  localparam int unsigned NumPhases     = 6;
  localparam int unsigned DrainCycles   = 14;
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = CFG_TEMP_COEF_WORD + 3'd1;
  localparam ptc_cfg_t CalTypical = '{c1: 16'd34982, c2: 16'd36352, c3: 16'd20328,
                                      c4: 16'd22354, c5: 16'd26646, c6: 16'd26146};
  localparam ptc_cfg_t CalSkew    = '{c1: 16'd0, c2: 16'hFFFF, c3: 16'hFFFF,
                                      c4: 16'd0, c5: 16'hFFFF, c6: 16'hFFFF};

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgW-1:0]     cfg_wdata_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [23:0]         raw_pressure_i;
  logic [23:0]         raw_temperature_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic signed [18:0]  temp_centi_o;
  logic signed [31:0]  press_centi_mbar_o;
  logic                low_temp_mode_o;

  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int          outstanding;
  int          fail_count;

  pressure_temp_compensation uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .raw_pressure_i, .raw_temperature_i,
    .out_valid_o, .out_ready_i, .temp_centi_o, .press_centi_mbar_o, .low_temp_mode_o
  );

  compensation_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .raw_pressure_i, .raw_temperature_i,
    .out_valid_i(out_valid_o), .out_ready_i, .temp_centi_i(temp_centi_o),
    .press_centi_mbar_i(press_centi_mbar_o), .low_temp_mode_i(low_temp_mode_o),
    .outstanding_o(outstanding), .fail_count_o(fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("** pressure_temp_compensation: FAILED **");
    $finish;
  end

  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic logic [23:0] clip24(input int v);
    if (v < 0) return 24'd0;
    if (v > 24'hFFFFFF) return 24'hFFFFFF;
    return 24'(v);
  endfunction

  function automatic ptc_cfg_t random_cal();
    return '{c1: 16'($urandom), c2: 16'($urandom), c3: 16'($urandom),
             c4: 16'($urandom), c5: 16'($urandom), c6: 16'($urandom)};
  endfunction

  task automatic send_sample(input logic [23:0] p, input logic [23:0] t);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i        <= 1'b1;
    raw_pressure_i    <= p;
    raw_temperature_i <= t;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic send_random(input ptc_cfg_t cal);
    int base, offs;
    logic [23:0] t;
    base = int'({cal.c5, 8'd0});
    if ($urandom_range(1)) begin
      t = 24'($urandom);
    end else begin
      offs = int'($urandom_range(0, 1 << $urandom_range(0, 20)));
      if ($urandom_range(1)) offs = -offs;
      t = clip24(base + offs);
    end
    send_sample(24'($urandom), t);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic put_cfg(input ptc_cfg_idx_e idx, input logic [CfgW-1:0] val);
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
  endtask

  task automatic load_cal(input ptc_cfg_t cal);
    cfg_we_i <= 1'b1;
    put_cfg(CFG_SENS_BASE, cal.c1);
    put_cfg(CFG_OFF_BASE, cal.c2);
    put_cfg(CFG_SENS_TEMP_COEF, cal.c3);
    put_cfg(CFG_OFF_TEMP_COEF, cal.c4);
    put_cfg(CFG_REF_TEMP_WORD, cal.c5);
    put_cfg(CFG_TEMP_COEF_WORD, cal.c6);
    cfg_idx_i   <= CfgIdxSpare | CfgIdxW'($urandom_range(1));
    cfg_wdata_i <= CfgW'($urandom);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    ptc_cfg_t    cal;
    int          base, dt_edge;
    int unsigned phase, n;
    rst_ni = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= CFG_SENS_BASE;
    cfg_wdata_i       <= '0;
    in_valid_i        <= 1'b0;
    raw_pressure_i    <= '0;
    raw_temperature_i <= '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_sample(24'd0, 24'd0);
    send_sample(24'hFFFFFF, 24'hFFFFFF);
    send_sample(24'($urandom), 24'($urandom));
    drain();

    cal = CalTypical;
    load_cal(cal);
    base    = int'({cal.c5, 8'd0});
    dt_edge = ((1 << 23) + int'(cal.c6) - 1) / int'(cal.c6);
    send_sample(24'd0, clip24(base));
    send_sample(24'hFFFFFF, clip24(base));
    send_sample(24'd6465444, clip24(base - 1));
    send_sample(24'd6465444, clip24(base - dt_edge));
    send_sample(24'd6465444, clip24(base - dt_edge + 1));
    send_sample(24'd6465444, clip24(base + 1));
    send_sample(24'd6465444, clip24(base - (1 << 20)));
    send_sample(24'd6465444, clip24(base + (1 << 20)));
    send_sample(24'd0, 24'd0);
    send_sample(24'hFFFFFF, 24'hFFFFFF);
    send_sample(24'hFFFFFF, 24'd0);
    send_sample(24'd0, 24'hFFFFFF);
    send_sample(24'hAAAAAA, 24'h555555);
    send_sample(24'h555555, 24'hAAAAAA);
    send_sample(24'd6465444, 24'd8077636);

    for (phase = 0; phase < NumPhases; phase++) begin
      drain();
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 66; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 66; end
        default: begin send_idle_pct = 9; stall_pct = 9; end
      endcase
      case (phase)
        0: cal = CalTypical;
        1: cal = '1;
        3: cal = CalSkew;
        4: cal = '0;
        default: cal = random_cal();
      endcase
      load_cal(cal);
      for (n = 0; n < ItemsPerPhase; n++)
        send_random(cal);
    end

    drain();
    if (fail_count == 0)
      $display("** pressure_temp_compensation: PASSED **");
    else
      $display("** pressure_temp_compensation: FAILED **");
    $finish;
  end

endmodule
